>>> rtl/mtee_pkg.sv
// Package for the MIDI track event encoder: command and byte transaction
// types, opcodes and MIDI constants. No dependencies.
`default_nettype none

package mtee_pkg;

    // Opcodes of the command channel
    localparam logic [2:0] OP_BEAT_ABS  = 3'd0;
    localparam logic [2:0] OP_BEAT_DLT  = 3'd1;
    localparam logic [2:0] OP_TEMPO     = 3'd2;
    localparam logic [2:0] OP_PROGRAM   = 3'd3;
    localparam logic [2:0] OP_END_TRACK = 3'd4;

    // MIDI constants
    localparam logic [7:0]  DATA_MASK     = 8'h7F;
    localparam logic [7:0]  VLQ_CONT      = 8'h80;
    localparam logic [7:0]  STAT_NOTE_ON  = 8'h90;
    localparam logic [7:0]  STAT_PROGRAM  = 8'hC0;
    localparam logic [7:0]  META_PREFIX   = 8'hFF;
    localparam logic [7:0]  META_TEMPO    = 8'h51;
    localparam logic [7:0]  META_TEMPO_LN = 8'h03;
    localparam logic [7:0]  META_EOT      = 8'h2F;
    localparam logic [31:0] VLQ_MAX       = 32'h0FFF_FFFF;

    // Buffer sizing
    localparam int MAX_BYTES  = 10;
    localparam int VLQ_BYTES  = 4;
    localparam int BODY_BYTES = 6;

    // One command transaction
    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] time_value;
        logic [6:0]  note;
        logic [3:0]  channel;
        logic [6:0]  velocity;
        logic [6:0]  program_req;
        logic [23:0] tempo_us;
    } cmd_t;

    // One track byte transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } trk_t;

endpackage

`default_nettype wire

>>> rtl/midi_track_event_encoder_unit.sv
// MIDI track event encoder top level: command holding register, event byte
// builder and byte serializer. Depends on mtee_pkg.
`default_nettype none

//  channel | dir | handshake           | payload
//  --------+-----+---------------------+--------------------------------
//  cmd     | in  | cmd_valid/cmd_stall | mtee_pkg::cmd_t, one event
//  trk     | out | trk_valid/trk_stall | mtee_pkg::trk_t, one track byte
//
// An event waits in the holding register, then is built in one
// pass and loaded into the serializer, which sends one byte per cycle
// while trk_stall is low. An event is 3 to 10 bytes long; the serializer's
// single byte port sets the rate. Events with no bytes send nothing.
// A new command is taken while the previous event is still being sent.
// Reset clears valids, counts, last time and running status.
// trk_stall freezes the serializer, and the holding register backs up cmd.
module midi_track_event_encoder_unit
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    output logic                  cmd_stall,
    input  wire mtee_pkg::cmd_t   cmd,
    output logic                  trk_valid,
    input  wire logic             trk_stall,
    output mtee_pkg::trk_t        trk
);

    mtee_pkg::cmd_t hold_reg;
    logic           hold_valid_reg;
    logic [31:0]    last_time_reg;
    logic [7:0]     run_stat_reg;
    logic [7:0]     ser_reg [mtee_pkg::MAX_BYTES];
    logic [3:0]     ser_cnt_reg;

    logic           cmd_acc;
    logic           trk_acc;
    logic           move;

    logic [32:0]    diff;
    logic [31:0]    delta;
    logic [31:0]    vlq_val;
    logic [6:0]     grp [mtee_pkg::VLQ_BYTES];
    logic [7:0]     vlq [mtee_pkg::VLQ_BYTES];
    logic [2:0]     vlq_n;
    logic [7:0]     body [mtee_pkg::BODY_BYTES];
    logic [2:0]     body_n;
    logic [7:0]     beat_stat;
    logic           send_stat;
    logic [7:0]     load [mtee_pkg::MAX_BYTES];
    logic [3:0]     load_cnt;
    logic [31:0]    last_time_next;
    logic [7:0]     run_stat_next;

    // Handshakes
    assign trk_valid = (ser_cnt_reg != 4'd0);
    assign trk_acc   = trk_valid && !trk_stall;
    assign move      = hold_valid_reg &&
                       ((ser_cnt_reg == 4'd0) || ((ser_cnt_reg == 4'd1) && trk_acc));
    assign cmd_stall = hold_valid_reg && !move;
    assign cmd_acc   = cmd_valid && !cmd_stall;

    assign trk.out_byte  = ser_reg[0];
    assign trk.last_byte = (ser_cnt_reg == 4'd1);

    // Delta: saturate on backwards time or above the VLQ range
    assign diff      = {1'b0, hold_reg.time_value} - {1'b0, last_time_reg};
    assign delta     = (hold_reg.op == mtee_pkg::OP_BEAT_ABS) ? diff[31:0]
                                                              : hold_reg.time_value;
    assign beat_stat = mtee_pkg::STAT_NOTE_ON | {4'd0, hold_reg.channel};
    assign send_stat = (beat_stat != run_stat_reg);

    always_comb
    begin
        if (((hold_reg.op == mtee_pkg::OP_BEAT_ABS) && diff[32]) ||
            (delta[31:28] != 4'd0))
        begin
            vlq_val = mtee_pkg::VLQ_MAX;
        end
        else
        begin
            vlq_val = delta;
        end
    end

    // VLQ groups, most significant first
    always_comb
    begin
        grp[0] = vlq_val[6:0];
        grp[1] = vlq_val[13:7];
        grp[2] = vlq_val[20:14];
        grp[3] = vlq_val[27:21];
        if (grp[3] != 7'd0)
        begin
            vlq[0] = mtee_pkg::VLQ_CONT | {1'b0, grp[3]};
            vlq[1] = mtee_pkg::VLQ_CONT | {1'b0, grp[2]};
            vlq[2] = mtee_pkg::VLQ_CONT | {1'b0, grp[1]};
            vlq[3] = {1'b0, grp[0]};
            vlq_n  = 3'd4;
        end
        else if (grp[2] != 7'd0)
        begin
            vlq[0] = mtee_pkg::VLQ_CONT | {1'b0, grp[2]};
            vlq[1] = mtee_pkg::VLQ_CONT | {1'b0, grp[1]};
            vlq[2] = {1'b0, grp[0]};
            vlq[3] = 8'd0;
            vlq_n  = 3'd3;
        end
        else if (grp[1] != 7'd0)
        begin
            vlq[0] = mtee_pkg::VLQ_CONT | {1'b0, grp[1]};
            vlq[1] = {1'b0, grp[0]};
            vlq[2] = 8'd0;
            vlq[3] = 8'd0;
            vlq_n  = 3'd2;
        end
        else
        begin
            vlq[0] = {1'b0, grp[0]};
            vlq[1] = 8'd0;
            vlq[2] = 8'd0;
            vlq[3] = 8'd0;
            vlq_n  = 3'd1;
        end
    end

    // Event body and state updates
    always_comb
    begin
        for (int i = 0; i < mtee_pkg::BODY_BYTES; i++)
        begin
            body[i] = 8'd0;
        end
        body_n         = 3'd0;
        last_time_next = last_time_reg;
        run_stat_next  = run_stat_reg;
        case (hold_reg.op)
            mtee_pkg::OP_BEAT_ABS, mtee_pkg::OP_BEAT_DLT:
            begin
                if (send_stat)
                begin
                    body[0] = beat_stat;
                    body[1] = {1'b0, hold_reg.note};
                    body[2] = {1'b0, hold_reg.velocity};
                    body[4] = {1'b0, hold_reg.note};
                    body_n  = 3'd6;
                end
                else
                begin
                    body[0] = {1'b0, hold_reg.note};
                    body[1] = {1'b0, hold_reg.velocity};
                    body[3] = {1'b0, hold_reg.note};
                    body_n  = 3'd5;
                end
                run_stat_next = beat_stat;
                if (hold_reg.op == mtee_pkg::OP_BEAT_ABS)
                begin
                    last_time_next = hold_reg.time_value;
                end
            end
            mtee_pkg::OP_TEMPO:
            begin
                body[0]       = mtee_pkg::META_PREFIX;
                body[1]       = mtee_pkg::META_TEMPO;
                body[2]       = mtee_pkg::META_TEMPO_LN;
                body[3]       = hold_reg.tempo_us[23:16];
                body[4]       = hold_reg.tempo_us[15:8];
                body[5]       = hold_reg.tempo_us[7:0];
                body_n        = 3'd6;
                run_stat_next = 8'd0;
            end
            mtee_pkg::OP_PROGRAM:
            begin
                body[0]       = 8'd0;
                body[1]       = mtee_pkg::STAT_PROGRAM | {4'd0, hold_reg.channel};
                body[2]       = {1'b0, hold_reg.program_req};
                body_n        = 3'd3;
                run_stat_next = mtee_pkg::STAT_PROGRAM | {4'd0, hold_reg.channel};
            end
            mtee_pkg::OP_END_TRACK:
            begin
                body[0] = 8'd0;
                body[1] = mtee_pkg::META_PREFIX;
                body[2] = mtee_pkg::META_EOT;
                body[3] = 8'd0;
                body_n  = 3'd4;
            end
            default:
            begin
                body_n = 3'd0;
            end
        endcase
    end

    // Join delta and body into the serializer image
    always_comb
    begin
        logic [2:0] vn;
        logic [3:0] idx;
        if ((hold_reg.op == mtee_pkg::OP_BEAT_ABS) || (hold_reg.op == mtee_pkg::OP_BEAT_DLT) ||
            (hold_reg.op == mtee_pkg::OP_TEMPO))
        begin
            vn = vlq_n;
        end
        else
        begin
            vn = 3'd0;
        end
        load_cnt = {1'b0, vn} + {1'b0, body_n};
        for (int i = 0; i < mtee_pkg::MAX_BYTES; i++)
        begin
            idx = 4'(i) - {1'b0, vn};
            if (4'(i) < {1'b0, vn})
            begin
                load[i] = vlq[i[1:0]];
            end
            else if (idx < 4'(mtee_pkg::BODY_BYTES))
            begin
                load[i] = body[idx[2:0]];
            end
            else
            begin
                load[i] = 8'd0;
            end
        end
    end

    // Holding register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (cmd_acc)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (move)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_acc)
        begin
            hold_reg <= cmd;
        end
    end

    // Track state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= 32'd0;
            run_stat_reg  <= 8'd0;
        end
        else if (move)
        begin
            last_time_reg <= last_time_next;
            run_stat_reg  <= run_stat_next;
        end
    end

    // Byte serializer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_cnt_reg <= 4'd0;
        end
        else if (move)
        begin
            ser_cnt_reg <= load_cnt;
        end
        else if (trk_acc)
        begin
            ser_cnt_reg <= ser_cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            ser_reg <= load;
        end
        else if (trk_acc)
        begin
            for (int i = 0; i < mtee_pkg::MAX_BYTES - 1; i++)
            begin
                ser_reg[i] <= ser_reg[i + 1];
            end
            ser_reg[mtee_pkg::MAX_BYTES - 1] <= 8'd0;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        ser_cnt_reg <= 4'(mtee_pkg::MAX_BYTES))
        else $error("serializer count out of range");

    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> hold_valid_reg)
        else $error("command stalled with empty holding register");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (move && (load_cnt != 4'd0)) |=> trk_valid)
        else $error("loaded event not presented");

    a_tempo_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (move && (hold_reg.op == mtee_pkg::OP_TEMPO)) |=> (run_stat_reg == 8'd0))
        else $error("tempo event did not clear running status");
`endif

endmodule

`default_nettype wire
